// ===== rtl/core/rrfp_pkg.sv =====
package rrfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned RoleW  = 4;
  localparam int unsigned TmoW   = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] TimeoutLimitRst = 8'd100;
  localparam logic [ByteW-1:0] SyncValueRst    = 8'h00;
  localparam logic [ByteW-1:0] ExpTypeRst      = 8'h04;
  localparam logic [ByteW-1:0] ComplMask       = 8'hff;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT_LIMIT = 2'd0,
    CFG_SYNC_VALUE    = 2'd1,
    CFG_EXP_TYPE      = 2'd2
  } rrfp_cfg_idx_e;

  typedef enum logic [0:0] {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } rrfp_func_e;

  typedef enum logic [3:0] {
    ST_HUNT  = 4'd0,
    ST_SEQ   = 4'd1,
    ST_SEQC  = 4'd2,
    ST_LENLO = 4'd3,
    ST_LENHI = 4'd4,
    ST_TYPE  = 4'd5,
    ST_RET   = 4'd6,
    ST_DATA  = 4'd7,
    ST_CRCLO = 4'd8,
    ST_CRCHI = 4'd9
  } rrfp_state_e;

  typedef enum logic [RoleW-1:0] {
    ROLE_HUNT   = 4'd0,
    ROLE_SYNC   = 4'd1,
    ROLE_SEQ    = 4'd2,
    ROLE_SEQC   = 4'd3,
    ROLE_LENLO  = 4'd4,
    ROLE_LENHI  = 4'd5,
    ROLE_TYPE   = 4'd6,
    ROLE_RET    = 4'd7,
    ROLE_DATA   = 4'd8,
    ROLE_CRCLO  = 4'd9,
    ROLE_CRCHI  = 4'd10,
    ROLE_REJECT = 4'd11
  } rrfp_role_e;

  typedef struct packed {
    logic [ByteW-1:0] timeout_limit;
    logic [ByteW-1:0] sync_value;
    logic [ByteW-1:0] expected_type;
  } rrfp_cfg_t;

  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] rx_byte;
  } rrfp_item_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    rrfp_role_e       role;
    logic [LenW-1:0]  data_index;
    logic             frame_done;
    logic             timed_out;
    logic [ByteW-1:0] seq_number;
    logic [LenW-1:0]  payload_length;
    logic [ByteW-1:0] return_code;
  } rrfp_result_t;

endpackage

// ===== rtl/core/radio_reply_frame_parser_core.sv =====
// Reply frame parser.
// Input channel (in_valid_i / in_ready_o): one request per event, either a
// received byte (func_i = 0, rx_byte_i) or one elapsed read-timeout period
// (func_i = 1). Output channel (out_valid_o / out_ready_i): exactly one
// result per request, in order: byte role, payload index, frame done,
// timeout abort and the current frame's sequence number, length and return
// code.
// The request passes from the input register through the parse logic into
// the result register, where it is held until taken. Throughput: one
// request per cycle while out_ready_i stays high; the parser state
// advances once per request as it moves into the result register.
// Stall: when out_ready_i is low the result register holds, the input
// register takes one more request, then in_ready_o drops until the result
// register drains. No request is dropped or duplicated.
// Reset (rst_ni low, async): both stages empty, parser hunting for sync,
// all frame fields and the timeout count zero, registers at their defaults
// (timeout limit 100, sync 0x00, type 0x04).
// Config: cfg_we_i writes cfg_wdata_i to register cfg_index_i (0 timeout
// limit, 1 sync value, 2 expected type); other indexes are ignored.
module radio_reply_frame_parser_core import rrfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   byte_out_o,
  output logic [RoleW-1:0]   role_o,
  output logic [LenW-1:0]    data_index_o,
  output logic               frame_done_o,
  output logic               timed_out_o,
  output logic [ByteW-1:0]   seq_number_o,
  output logic [LenW-1:0]    payload_length_o,
  output logic [ByteW-1:0]   return_code_o
);

  rrfp_cfg_t    cfg_q;
  rrfp_item_t   in_item, stage_item;
  rrfp_result_t parse_res, out_res;
  logic         stage_valid, step;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_limit <= TimeoutLimitRst;
      cfg_q.sync_value    <= SyncValueRst;
      cfg_q.expected_type <= ExpTypeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_wdata_i;
        CFG_SYNC_VALUE:    cfg_q.sync_value    <= cfg_wdata_i;
        CFG_EXP_TYPE:      cfg_q.expected_type <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_item.func    = func_i;
  assign in_item.rx_byte = rx_byte_i;

  rrfp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (step),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  // parser state commits only when its result is loaded downstream
  rrfp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stage_item),
    .cfg_i    (cfg_q),
    .result_o (parse_res)
  );

  rrfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (stage_valid),
    .take_o      (step),
    .result_i    (parse_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign byte_out_o       = out_res.byte_out;
  assign role_o           = out_res.role;
  assign data_index_o     = out_res.data_index;
  assign frame_done_o     = out_res.frame_done;
  assign timed_out_o      = out_res.timed_out;
  assign seq_number_o     = out_res.seq_number;
  assign payload_length_o = out_res.payload_length;
  assign return_code_o    = out_res.return_code;

endmodule

// ===== rtl/core/rrfp_in_stage.sv =====
module rrfp_in_stage import rrfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rrfp_item_t item_i,
  input  logic       take_i,
  output logic       valid_o,
  output rrfp_item_t item_o
);

  logic       valid_q, valid_d;
  rrfp_item_t item_q;

  // slot frees up in the same cycle it is drained
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/rrfp_parser.sv =====
module rrfp_parser import rrfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  rrfp_item_t   item_i,
  input  rrfp_cfg_t    cfg_i,
  output rrfp_result_t result_o
);

  rrfp_state_e      state_q, state_d;
  logic [ByteW-1:0] seq_q, seq_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  remain_q, remain_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] ret_q, ret_d;
  logic [TmoW-1:0]  tmo_q, tmo_d;
  logic [TmoW-1:0]  tmo_inc;
  logic [ByteW-1:0] b;
  rrfp_role_e       role;
  logic [LenW-1:0]  data_idx;
  logic             done, tout;

  assign b       = item_i.rx_byte;
  assign tmo_inc = tmo_q + TmoW'(1);

  always_comb begin
    state_d  = state_q;
    seq_d    = seq_q;
    len_d    = len_q;
    remain_d = remain_q;
    pos_d    = pos_q;
    ret_d    = ret_q;
    tmo_d    = tmo_q;
    role     = ROLE_HUNT;
    data_idx = '0;
    done     = 1'b0;
    tout     = 1'b0;

    if (item_i.func == FUNC_TICK) begin
      tmo_d = tmo_inc;
      if (tmo_inc > {1'b0, cfg_i.timeout_limit}) begin
        tout    = 1'b1;
        tmo_d   = '0;
        state_d = ST_HUNT;
      end
    end else begin
      case (state_q)
        ST_SEQ: begin
          seq_d   = b;
          role    = ROLE_SEQ;
          state_d = ST_SEQC;
        end
        ST_SEQC: begin
          if (seq_q == (b ^ ComplMask)) begin
            role    = ROLE_SEQC;
            state_d = ST_LENLO;
          end else begin
            role    = ROLE_REJECT;
            state_d = ST_HUNT;
          end
        end
        ST_LENLO: begin
          len_d   = {len_q[LenW-1:ByteW], b};
          role    = ROLE_LENLO;
          state_d = ST_LENHI;
        end
        ST_LENHI: begin
          len_d   = {b, len_q[ByteW-1:0]};
          role    = ROLE_LENHI;
          state_d = ST_TYPE;
        end
        ST_TYPE: begin
          if (b == cfg_i.expected_type) begin
            role    = ROLE_TYPE;
            state_d = ST_RET;
          end else begin
            role    = ROLE_REJECT;
            state_d = ST_HUNT;
          end
        end
        ST_RET: begin
          ret_d = b;
          role  = ROLE_RET;
          if (len_q != '0) begin
            remain_d = len_q;
            pos_d    = '0;
            state_d  = ST_DATA;
          end else begin
            state_d = ST_CRCLO;
          end
        end
        ST_DATA: begin
          role     = ROLE_DATA;
          data_idx = pos_q;
          pos_d    = pos_q + LenW'(1);
          remain_d = remain_q - LenW'(1);
          if (remain_d == '0) begin
            state_d = ST_CRCLO;
          end
        end
        ST_CRCLO: begin
          role    = ROLE_CRCLO;
          state_d = ST_CRCHI;
        end
        ST_CRCHI: begin
          role    = ROLE_CRCHI;
          done    = 1'b1;
          state_d = ST_HUNT;
          tmo_d   = '0;
        end
        default: begin
          // hunting; unused codes land here too
          state_d = ST_HUNT;
          if (b == cfg_i.sync_value) begin
            role    = ROLE_SYNC;
            seq_d   = '0;
            len_d   = '0;
            ret_d   = '0;
            state_d = ST_SEQ;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      seq_q    <= '0;
      len_q    <= '0;
      remain_q <= '0;
      pos_q    <= '0;
      ret_q    <= '0;
      tmo_q    <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
      ret_q    <= ret_d;
      tmo_q    <= tmo_d;
    end
  end

  always_comb begin
    result_o.byte_out       = (item_i.func == FUNC_TICK) ? '0 : b;
    result_o.role           = role;
    result_o.data_index     = data_idx;
    result_o.frame_done     = done;
    result_o.timed_out      = tout;
    result_o.seq_number     = seq_d;
    result_o.payload_length = len_d;
    result_o.return_code    = ret_d;
  end

endmodule

// ===== rtl/core/rrfp_out_stage.sv =====
module rrfp_out_stage import rrfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         src_valid_i,
  output logic         take_o,
  input  rrfp_result_t result_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rrfp_result_t result_o
);

  logic         valid_q, valid_d;
  rrfp_result_t result_q;

  // load whenever the held result is gone or leaves this cycle
  assign take_o  = src_valid_i && (!valid_q || out_ready_i);
  assign valid_d = take_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ===== rtl/core/rrfp_checker.sv =====
module rrfp_checker import rrfp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [ByteW-1:0]   byte_out_o,
  input logic [RoleW-1:0]   role_o,
  input logic [LenW-1:0]    data_index_o,
  input logic               frame_done_o,
  input logic               timed_out_o,
  input logic [ByteW-1:0]   seq_number_o,
  input logic [LenW-1:0]    payload_length_o,
  input logic [ByteW-1:0]   return_code_o
);

  // done only on the second crc byte
  a_done_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> role_o == ROLE_CRCHI)
    else $error("frame_done without crc-high role");

  // a timeout tick carries no byte and no role
  a_tout_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timed_out_o |-> role_o == ROLE_HUNT && byte_out_o == '0
      && !frame_done_o)
    else $error("timeout result carries byte data");

  // payload index only on data bytes
  a_idx_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_index_o != '0 |-> role_o == ROLE_DATA)
    else $error("data_index set outside payload");

  // a sync result starts a fresh frame record
  a_sync_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && role_o == ROLE_SYNC |-> seq_number_o == '0
      && payload_length_o == '0 && return_code_o == '0)
    else $error("sync did not clear frame fields");

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(role_o)
      && $stable(byte_out_o))
    else $error("result changed under stall");

endmodule

bind radio_reply_frame_parser_core rrfp_checker u_rrfp_checker (.*);

// ===== test/tb_radio_reply_frame_parser_core.sv =====
`timescale 1ns / 1ps

// Reply frame parser bench.
// A short table of hand-picked requests opens the run, then framed random
// traffic under several register settings. Every accepted request is run
// through a local parser model and the outcome is queued. Results coming
// out of the block are popped and compared against that queue.
module tb_radio_reply_frame_parser_core;
  import rrfp_pkg::*;

  localparam int unsigned HoldCycles  = 200;   // long receiver hold-off
  localparam int unsigned StuckLimit  = 2000;  // cycles with no handshake at all
  localparam int unsigned DrainCycles = 8;     // quiet time after the last result
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned MaxReports  = 10;

  // Index 3 is not a register; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               func_i;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ByteW-1:0]   byte_out_o;
  logic [RoleW-1:0]   role_o;
  logic [LenW-1:0]    data_index_o;
  logic               frame_done_o;
  logic               timed_out_o;
  logic [ByteW-1:0]   seq_number_o;
  logic [LenW-1:0]    payload_length_o;
  logic [ByteW-1:0]   return_code_o;

  radio_reply_frame_parser_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .byte_out_o,
    .role_o,
    .data_index_o,
    .frame_done_o,
    .timed_out_o,
    .seq_number_o,
    .payload_length_o,
    .return_code_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model: register copies and frame state
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] lim_r, sync_r, type_r;
  rrfp_state_e      pst;
  logic [ByteW-1:0] seq_first_q;
  logic [LenW-1:0]  decl_len_q;
  logic [LenW-1:0]  remain_q;
  logic [LenW-1:0]  pos_q;
  logic [ByteW-1:0] ret_q;
  logic [TmoW-1:0]  tmo_cnt_q;

  rrfp_result_t pending_replies [$];
  rrfp_item_t   byte_stream [$];

  bit idle_on  = 1'b1;   // random gaps on both sides
  bit stall_rx = 1'b0;   // one-shot long receiver hold-off

  int unsigned err_count;
  int unsigned n_requests;
  int unsigned n_done, n_reject, n_abort, n_data;
  int unsigned stuck_cycles;

  // Advances the model by one request and returns the result it produces.
  function automatic rrfp_result_t parse_event(input logic f, input logic [ByteW-1:0] b);
    rrfp_result_t r;
    r = '0;
    r.role = ROLE_HUNT;
    if (f == FUNC_TICK) begin
      // count runs from reset or the last frame done or abort; abort fires even while hunting
      tmo_cnt_q = tmo_cnt_q + 1'b1;
      if (tmo_cnt_q > {1'b0, lim_r}) begin
        r.timed_out = 1'b1;
        tmo_cnt_q = '0;
        pst = ST_HUNT;
      end
    end else begin
      r.byte_out = b;
      case (pst)
        ST_SEQ: begin
          seq_first_q = b;
          r.role = ROLE_SEQ;
          pst = ST_SEQC;
        end
        ST_SEQC: begin
          if (seq_first_q == (b ^ ComplMask)) begin
            r.role = ROLE_SEQC;
            pst = ST_LENLO;
          end else begin
            r.role = ROLE_REJECT;
            pst = ST_HUNT;
          end
        end
        ST_LENLO: begin
          decl_len_q[7:0] = b;
          r.role = ROLE_LENLO;
          pst = ST_LENHI;
        end
        ST_LENHI: begin
          decl_len_q[15:8] = b;
          r.role = ROLE_LENHI;
          pst = ST_TYPE;
        end
        ST_TYPE: begin
          if (b == type_r) begin
            r.role = ROLE_TYPE;
            pst = ST_RET;
          end else begin
            r.role = ROLE_REJECT;
            pst = ST_HUNT;
          end
        end
        ST_RET: begin
          ret_q = b;
          r.role = ROLE_RET;
          // zero length skips straight to the CRC
          if (decl_len_q != '0) begin
            remain_q = decl_len_q;
            pos_q = '0;
            pst = ST_DATA;
          end else begin
            pst = ST_CRCLO;
          end
        end
        ST_DATA: begin
          r.role = ROLE_DATA;
          r.data_index = pos_q;
          pos_q = pos_q + 1'b1;
          remain_q = remain_q - 1'b1;
          if (remain_q == '0) pst = ST_CRCLO;
        end
        ST_CRCLO: begin
          r.role = ROLE_CRCLO;
          pst = ST_CRCHI;
        end
        ST_CRCHI: begin
          r.role = ROLE_CRCHI;
          r.frame_done = 1'b1;
          pst = ST_HUNT;
          tmo_cnt_q = '0;
        end
        default: begin
          pst = ST_HUNT;
          if (b == sync_r) begin
            // new frame wipes the held frame fields
            r.role = ROLE_SYNC;
            seq_first_q = '0;
            decl_len_q = '0;
            ret_q = '0;
            pst = ST_SEQ;
          end
        end
      endcase
    end
    r.seq_number = seq_first_q;
    r.payload_length = decl_len_q;
    r.return_code = ret_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed requests. Role, done and abort are typed in on pinned rows and
  // override the model there; the remaining fields always come from the model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] data;
    logic             pinned;
    rrfp_role_e       role;
    logic             done;
    logic             tmo;
  } dir_row_t;

  localparam int NumDirRows = 20;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // hunting after reset: stray byte and a tick
    '{FUNC_BYTE, 8'h55, 1'b1, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_TICK, 8'ha3, 1'b1, ROLE_HUNT,   1'b0, 1'b0},
    // zero-length frame, seq 0x00 / 0xff
    '{FUNC_BYTE, 8'h00, 1'b1, ROLE_SYNC,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h00, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'hff, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h00, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h00, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h04, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'hff, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h3c, 1'b1, ROLE_CRCLO,  1'b0, 1'b0},
    '{FUNC_BYTE, 8'hc3, 1'b1, ROLE_CRCHI,  1'b1, 1'b0},
    // bad complement
    '{FUNC_BYTE, 8'h00, 1'b1, ROLE_SYNC,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h12, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h12, 1'b1, ROLE_REJECT, 1'b0, 1'b0},
    // max declared length, then a bad type byte
    '{FUNC_BYTE, 8'h00, 1'b1, ROLE_SYNC,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'hff, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h00, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'hff, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'hff, 1'b0, ROLE_HUNT,   1'b0, 1'b0},
    '{FUNC_BYTE, 8'h05, 1'b1, ROLE_REJECT, 1'b0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one request and returns at the edge where it is taken. Valid stays
  // high on return; the next call or settle() sets it in that same step.
  task automatic send_request(input rrfp_item_t it, input logic pin, input rrfp_role_e role,
                              input logic done, input logic tmo);
    rrfp_result_t r;
    while (idle_on && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= it.func;
    rx_byte_i  <= it.rx_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = parse_event(it.func, it.rx_byte);
    if (pin) begin
      r.role       = role;
      r.frame_done = done;
      r.timed_out  = tmo;
    end
    pending_replies.push_back(r);
    n_requests++;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Only called once the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_TIMEOUT_LIMIT: lim_r  = val;
      CFG_SYNC_VALUE:    sync_r = val;
      CFG_EXP_TYPE:      type_r = val;
      default: ;
    endcase
  endtask

  // Queues one received byte, now and then preceded by a few timeout ticks.
  task automatic add_byte(input logic [ByteW-1:0] b);
    int unsigned n_ticks;
    if ($urandom_range(24) == 0) begin
      n_ticks = $urandom_range(3, 1);
      repeat (n_ticks) byte_stream.push_back({FUNC_TICK, 8'($urandom)});
    end
    byte_stream.push_back({FUNC_BYTE, b});
  endtask

  // Mostly well-formed frames with random content; the rest is line noise,
  // bad complement, bad type and frames cut short.
  task automatic add_frame();
    int unsigned kind, len, cut, start;
    logic [ByteW-1:0] seq_b;
    kind  = $urandom_range(99);
    seq_b = 8'($urandom);
    if (kind < 12) begin
      repeat ($urandom_range(4, 1)) add_byte(($urandom_range(3) == 0) ? sync_r : 8'($urandom));
      return;
    end
    len   = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
    start = byte_stream.size();
    add_byte(sync_r);
    add_byte(seq_b);
    add_byte((kind < 20) ? seq_b : (seq_b ^ ComplMask));
    add_byte(len[7:0]);
    add_byte(len[15:8]);
    add_byte((kind >= 20 && kind < 28) ? (type_r ^ (8'd1 << $urandom_range(7))) : type_r);
    add_byte(8'($urandom));
    repeat (len) add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    if (kind >= 28 && kind < 34) begin
      cut = $urandom_range(7, 1);
      while (byte_stream.size() > start + cut) void'(byte_stream.pop_back());
    end
  endtask

  task automatic run_random(input int unsigned n);
    byte_stream.delete();
    while (byte_stream.size() < n) add_frame();
    while (byte_stream.size() > 0) send_request(byte_stream.pop_front(), 1'b0, ROLE_HUNT,
                                                1'b0, 1'b0);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random ready, plus the one long hold-off. While held, the
  // sender keeps offering, so the result stage and the input stage fill and
  // in_ready_o has to drop.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_rx) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        stall_rx = 1'b0;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < 23);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Outputs are read at the edge, before any update lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    rrfp_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.byte_out       = byte_out_o;
      got.role           = rrfp_role_e'(role_o);
      got.data_index     = data_index_o;
      got.frame_done     = frame_done_o;
      got.timed_out      = timed_out_o;
      got.seq_number     = seq_number_o;
      got.payload_length = payload_length_o;
      got.return_code    = return_code_o;
      if (pending_replies.size() == 0) begin
        if (err_count < MaxReports)
          $display("%0t: result with no request outstanding: %p", $realtime, got);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        if (want.frame_done) n_done++;
        if (want.timed_out) n_abort++;
        if (want.role == ROLE_REJECT) n_reject++;
        if (want.role == ROLE_DATA) n_data++;
        if (got !== want) begin
          if (err_count < MaxReports) begin
            $display("%0t: mismatch (expected / actual)", $realtime);
            $display("  byte %h/%h role %0d/%0d index %h/%h done %b/%b abort %b/%b",
                     want.byte_out, got.byte_out, want.role, got.role, want.data_index,
                     got.data_index, want.frame_done, got.frame_done, want.timed_out,
                     got.timed_out);
            $display("  seq %h/%h length %h/%h return %h/%h", want.seq_number,
                     got.seq_number, want.payload_length, got.payload_length,
                     want.return_code, got.return_code);
          end
          err_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $realtime,
               StuckLimit, pending_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_BYTE;
    rx_byte_i   = '0;
    out_ready_i = 1'b0;
    lim_r       = TimeoutLimitRst;
    sync_r      = SyncValueRst;
    type_r      = ExpTypeRst;
    pst         = ST_HUNT;
    seq_first_q = '0;
    decl_len_q  = '0;
    remain_q    = '0;
    pos_q       = '0;
    ret_q       = '0;
    tmo_cnt_q   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset register values.
    for (int i = 0; i < NumDirRows; i++)
      send_request({DirRows[i].func, DirRows[i].data}, DirRows[i].pinned, DirRows[i].role,
                   DirRows[i].done, DirRows[i].tmo);
    settle();

    // Small limit, non-zero sync.
    write_reg(CFG_TIMEOUT_LIMIT, 8'd3);
    write_reg(CFG_SYNC_VALUE, 8'h7e);
    run_random(PhaseItems);

    // Low extremes of the limit, all-ones sync and type, under the long hold-off.
    write_reg(CFG_TIMEOUT_LIMIT, 8'd0);
    write_reg(CFG_SYNC_VALUE, 8'hff);
    write_reg(CFG_EXP_TYPE, 8'hff);
    stall_rx = 1'b1;
    run_random(PhaseItems);

    // Top limit, all-zero sync and type, back to back with no gaps.
    idle_on = 1'b0;
    write_reg(CFG_TIMEOUT_LIMIT, 8'd255);
    write_reg(CFG_SYNC_VALUE, 8'h00);
    write_reg(CFG_EXP_TYPE, 8'h00);
    run_random(PhaseItems);
    idle_on = 1'b1;

    // Random settings; a write to the spare index must not disturb anything.
    write_reg(CFG_TIMEOUT_LIMIT, 8'($urandom_range(8, 1)));
    write_reg(CFG_SYNC_VALUE, 8'($urandom));
    write_reg(CFG_EXP_TYPE, 8'($urandom));
    write_reg(CfgIdxSpare, 8'($urandom));
    run_random(PhaseItems);

    // Reset-like limit and type with an odd sync byte.
    write_reg(CFG_TIMEOUT_LIMIT, TimeoutLimitRst);
    write_reg(CFG_SYNC_VALUE, 8'ha5);
    write_reg(CFG_EXP_TYPE, ExpTypeRst);
    run_random(PhaseItems);

    $display("Ran %0d requests over 6 register settings (limit 0 and 255 included).",
             n_requests);
    $display("Seen: %0d frames done, %0d rejects, %0d timeout aborts, %0d payload bytes.",
             n_done, n_reject, n_abort, n_data);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
